>>> hdl/psfet_pkg.sv
// ----------------------------------------------------------------------------
// psfet_pkg: shared types and constants of the flow entropy tracker
// Field widths, status codes and the divider request and response types used by the datapath.
// ----------------------------------------------------------------------------
package psfet_pkg;

  localparam int unsigned SourceSlotsDefault = 64;
  localparam int unsigned WindowLenDefault   = 100;
  localparam int unsigned FullScale          = 25600;

  localparam int unsigned InDataW  = 136;  // src, dst, packets, duration, slot, pad
  localparam int unsigned OutDataW = 264;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusFull  = 2'd1,
    StatusEmpty = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] windows_done;
    logic [15:0] entropy_slope;
    logic [14:0] mean_entropy;
    logic [31:0] dst_change_total;
    logic [47:0] duration_sum;
    logic [31:0] flow_sum;
    logic [47:0] packet_sum;
    logic [31:0] source_addr;
    logic [14:0] window_entropy;
    logic        window_done;
    logic [5:0]  slot_index;
    logic [1:0]  status;
  } result_t;

  // Divider handshake between the sequencer and the shared divider.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [47:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

endpackage

>>> hdl/psfet_ram.sv
// ----------------------------------------------------------------------------
// psfet_ram: generic single-port RAM
// One write and one read per cycle at the same address, registered read data.
// ----------------------------------------------------------------------------
module psfet_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> hdl/psfet_div.sv
// ----------------------------------------------------------------------------
// psfet_div: shared restoring divider
// One quotient bit per cycle, 64-bit numerator, 48-bit denominator.
// ----------------------------------------------------------------------------
module psfet_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psfet_pkg::div_req_t req_i,
  output psfet_pkg::div_rsp_t rsp_o
);

  logic [63:0] quo_q, quo_d;
  logic [48:0] rem_q, rem_d;
  logic [47:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [48:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[47:0], quo_q[63]};
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = 7'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift one numerator bit in, subtract where it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

>>> hdl/psfet_log2.sv
// ----------------------------------------------------------------------------
// psfet_log2: iterative log2 in Q32
// Normalize, then square the Q30 mantissa once per cycle for 32 fraction bits.
// ----------------------------------------------------------------------------
module psfet_log2 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [7:0]  x_i,
  output logic        done_o,
  output logic [34:0] log_o
);

  logic [31:0] m_q, m_d;
  logic [31:0] frac_q, frac_d;
  logic [2:0]  n_q, n_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [63:0] sq;
  logic [33:0] msh;
  logic [2:0]  lead;

  always_comb begin
    lead = 3'd0;
    for (int b = 1; b < 8; b++) begin
      if (x_i[b]) lead = 3'(b);
    end
  end

  assign sq  = 64'(m_q) * 64'(m_q);
  assign msh = sq[63:30];

  always_comb begin
    m_d    = m_q;
    frac_d = frac_q;
    n_d    = n_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      n_d    = lead;
      m_d    = 32'({x_i, 30'd0} >> lead);
      frac_d = '0;
      cnt_d  = '0;
      busy_d = (x_i != 8'd0);
      done_d = (x_i == 8'd0);
    end else if (busy_q) begin
      if (msh >= 34'h080000000) begin
        m_d    = msh[32:1];
        frac_d = {frac_q[30:0], 1'b1};
      end else begin
        m_d    = msh[31:0];
        frac_d = {frac_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      n_q    <= '0;
      frac_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      n_q    <= n_d;
      frac_q <= frac_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d;
  end

  assign done_o = done_q;
  assign log_o  = {n_q, frac_q};

endmodule

>>> hdl/per_source_flow_entropy_tracker_top.sv
// ----------------------------------------------------------------------------
// per_source_flow_entropy_tracker_top: per-source flow totals and window entropy
// Source table, saturating totals, destination windows and their entropy.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata fields (low bit up)                    | tuser
//  s_axis  | in  | src, dst, fwd_packets, flow_duration, slot   | action
//  m_axis  | out | status .. windows_done (see result_t)        | none
//
// Work: a read runs up to two 64-step divides (mean and slope). A flow
// compares each stored source in turn during the search, then runs the same
// divides; a flow that closes a window adds a pass of W+W*W window reads for
// the counts, one log per distinct destination and one divide.
// Reset: clears the slot count and the sequencer; the tables need no sweep.
// Stalls: the block is not ready from acceptance until its result is taken.
//
module per_source_flow_entropy_tracker_top #(
  parameter int unsigned SOURCE_SLOTS = psfet_pkg::SourceSlotsDefault,
  parameter int unsigned WINDOW_LEN   = psfet_pkg::WindowLenDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // src_addr[31:0], dst_addr[63:32], fwd_packets[95:64], flow_duration[127:96],
  // read_slot[133:128]
  input  logic [psfet_pkg::InDataW-1:0] s_axis_tdata_i,
  // action
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // status, slot_index, window_done, window_entropy, source_addr, packet_sum,
  // flow_sum, duration_sum, dst_change_total, mean_entropy, entropy_slope,
  // windows_done
  output logic [psfet_pkg::OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned SW = $clog2(SOURCE_SLOTS);
  localparam int unsigned CW = $clog2(SOURCE_SLOTS + 1);
  localparam int unsigned WW = $clog2(WINDOW_LEN);
  localparam int unsigned FW = $clog2(WINDOW_LEN + 1);
  localparam int unsigned WD = SOURCE_SLOTS * WINDOW_LEN;
  localparam int unsigned AW = $clog2(WD);
  // slot record: source, packets, flows, duration, changes, last dst,
  // fill, entropy total, first, latest, tally
  localparam int unsigned RW = 32 + 48 + 32 + 48 + 32 + 32 + FW + 32 + 15 + 15 + 16;

  typedef enum logic [13:0] {
    StIdle   = 14'b00000000000001,
    StSearch = 14'b00000000000010,
    StUpdate = 14'b00000000000100,
    StWrWin  = 14'b00000000001000,
    StOuterR = 14'b00000000010000,
    StInnerR = 14'b00000000100000,
    StInnerC = 14'b00000001000000,
    StLogC   = 14'b00000010000000,
    StLogW   = 14'b00000100000000,
    StDivH   = 14'b00001000000000,
    StRecord = 14'b00010000000000,
    StDivM   = 14'b00100000000000,
    StDivS   = 14'b01000000000000,
    StOut    = 14'b10000000000000
  } state_e;

  typedef struct packed {
    logic [31:0]   src;
    logic [47:0]   pkt;
    logic [31:0]   flw;
    logic [47:0]   dur;
    logic [31:0]   chg;
    logic [31:0]   last;
    logic [FW-1:0] fill;
    logic [31:0]   etot;
    logic [14:0]   efirst;
    logic [14:0]   elast;
    logic [15:0]   tally;
  } slot_rec_t;

  state_e    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic      act_q;
  logic [31:0] src_q, dst_q, pkt_in_q, dur_in_q;
  logic [SW-1:0] slot_q, slot_d;
  slot_rec_t rec_q, rec_d;
  psfet_pkg::result_t res_q, res_d;
  logic [1:0] phase_q, phase_d;

  // slot table
  logic          tab_we;
  logic [SW-1:0] tab_addr;
  slot_rec_t     tab_wdata, tab_rdata;

  psfet_ram #(.Width(RW), .Depth(SOURCE_SLOTS)) u_tab (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .addr_i  (tab_addr),
    .wdata_i (tab_wdata),
    .rdata_o (tab_rdata)
  );

  // window store
  logic          win_we;
  logic [AW-1:0] win_addr;
  logic [31:0]   win_wdata, win_rdata;

  psfet_ram #(.Width(32), .Depth(WD)) u_win (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .addr_i  (win_addr),
    .wdata_i (win_wdata),
    .rdata_o (win_rdata)
  );

  // entropy pass
  logic [WW-1:0] a_q, a_d, b_q, b_d;
  logic [31:0]   wa_q, wa_d;
  logic          seen_q, seen_d;
  logic [7:0]    cnt_q, cnt_d;
  logic [63:0]   s_q, s_d;
  logic [34:0]   lw_q, lw_d;
  logic [AW-1:0] base_q, base_d;
  logic [14:0]   ent_h;

  logic        lg_start;
  logic [7:0]  lg_x;
  logic        lg_done;
  logic [34:0] lg_out;

  psfet_log2 u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lg_start),
    .x_i     (lg_x),
    .done_o  (lg_done),
    .log_o   (lg_out)
  );

  psfet_pkg::div_req_t dv_req;
  psfet_pkg::div_rsp_t dv_rsp;

  psfet_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dv_req),
    .rsp_o  (dv_rsp)
  );

  logic        in_fire, out_fire;
  logic [15:0] slope_mag_q, slope_mag_d;
  logic        slope_neg_q, slope_neg_d;
  logic [48:0] psum, dsum;
  logic [63:0] den_full;
  logic [34:0] ldiff;
  logic [14:0] dlt;
  logic [15:0] nm1;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = (state_q == StOut);
  assign m_axis_tdata_o  = {1'b0, res_q};

  assign psum     = 49'(rec_q.pkt) + 49'(pkt_in_q);
  assign dsum     = 49'(rec_q.dur) + 49'(dur_in_q);
  assign den_full = 64'(WINDOW_LEN) * 64'(lw_q);
  assign ldiff    = lw_q - lg_out;
  assign nm1      = rec_q.tally - 16'd1;
  assign dlt      = (rec_q.elast >= rec_q.efirst) ? rec_q.elast - rec_q.efirst
                                                  : rec_q.efirst - rec_q.elast;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    slot_d    = slot_q;
    rec_d     = rec_q;
    res_d     = res_q;
    phase_d   = phase_q;
    a_d       = a_q;
    b_d       = b_q;
    wa_d      = wa_q;
    seen_d    = seen_q;
    cnt_d     = cnt_q;
    s_d       = s_q;
    lw_d      = lw_q;
    base_d    = base_q;
    ent_h     = '0;
    slope_mag_d = slope_mag_q;
    slope_neg_d = slope_neg_q;
    tab_we    = 1'b0;
    tab_addr  = slot_q;
    tab_wdata = rec_q;
    win_we    = 1'b0;
    win_addr  = base_q + AW'(a_q);
    win_wdata = dst_q;
    lg_start  = 1'b0;
    lg_x      = cnt_q;
    dv_req    = '0;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          res_d   = '0;
          idx_d   = '0;
          phase_d = '0;
          if (s_axis_tuser_i) begin
            res_d.slot_index = s_axis_tdata_i[133:128];
            slot_d = SW'(s_axis_tdata_i[133:128]);
            if (CW'(s_axis_tdata_i[133:128]) >= count_q ||
                32'(s_axis_tdata_i[133:128]) >= 32'(SOURCE_SLOTS)) begin
              res_d.status = psfet_pkg::StatusEmpty;
              state_d = StOut;
            end else begin
              tab_addr = SW'(s_axis_tdata_i[133:128]);
              state_d  = StUpdate;
            end
          end else begin
            tab_addr = '0;
            state_d  = StSearch;
          end
        end
      end

      // read the slots in turn: issue each read, then compare
      StSearch: begin
        if (phase_q == 2'd0) begin
          tab_addr = SW'(idx_q);
          phase_d  = 2'd1;
          if (idx_q >= count_q) begin
            if (count_q >= CW'(SOURCE_SLOTS)) begin
              res_d.status = psfet_pkg::StatusFull;
              state_d = StOut;
            end else begin
              slot_d    = SW'(count_q);
              count_d   = count_q + CW'(1);
              rec_d     = '0;
              rec_d.src = src_q;
              phase_d   = 2'd2;
              state_d   = StUpdate;
            end
          end
        end else begin
          phase_d = 2'd0;
          if (tab_rdata.src == src_q) begin
            slot_d    = SW'(idx_q);
            rec_d     = tab_rdata;
            phase_d   = 2'd2;
            state_d   = StUpdate;
          end else begin
            idx_d = idx_q + CW'(1);
          end
        end
      end

      StUpdate: begin
        if (act_q) begin
          if (phase_q == 2'd0) begin
            phase_d = 2'd1;
          end else begin
            rec_d   = tab_rdata;
            state_d = StDivM;
            phase_d = 2'd0;
          end
        end else begin
          if (rec_q.flw == 32'd0 || rec_q.last != dst_q) begin
            rec_d.chg = (rec_q.chg == '1) ? rec_q.chg : rec_q.chg + 32'd1;
          end
          rec_d.last = dst_q;
          rec_d.flw  = (rec_q.flw == '1) ? rec_q.flw : rec_q.flw + 32'd1;
          rec_d.pkt  = psum[48] ? '1 : psum[47:0];
          rec_d.dur  = dsum[48] ? '1 : dsum[47:0];
          base_d     = AW'(32'(slot_q) * 32'(WINDOW_LEN));
          a_d        = (rec_q.fill >= FW'(WINDOW_LEN)) ? '0 : WW'(rec_q.fill);
          state_d    = StWrWin;
        end
      end

      StWrWin: begin
        win_we = 1'b1;
        if (a_q == WW'(WINDOW_LEN - 1)) begin
          rec_d.fill = '0;
          res_d.window_done = 1'b1;
          a_d     = '0;
          s_d     = '0;
          lg_x    = 8'(WINDOW_LEN);
          lg_start = 1'b1;
          state_d = StLogW;
        end else begin
          rec_d.fill = FW'(a_q) + FW'(1);
          state_d = StRecord;
        end
      end

      StLogW: begin
        if (lg_done) begin
          lw_d    = lg_out;
          state_d = StOuterR;
          phase_d = 2'd0;
        end
      end

      // fetch w[a], then scan b for an earlier copy and count the copies from a onward
      StOuterR: begin
        win_addr = base_q + AW'(a_q);
        if (phase_q == 2'd0) begin
          phase_d = 2'd1;
        end else begin
          wa_d    = win_rdata;
          b_d     = '0;
          seen_d  = 1'b0;
          cnt_d   = '0;
          phase_d = 2'd0;
          state_d = StInnerR;
        end
      end

      StInnerR: begin
        win_addr = base_q + AW'(b_q);
        state_d  = StInnerC;
      end

      StInnerC: begin
        if (win_rdata == wa_q) begin
          if (b_q < a_q) begin
            seen_d = 1'b1;
          end else begin
            cnt_d = cnt_q + 8'd1;
          end
        end
        if (b_q == WW'(WINDOW_LEN - 1)) begin
          state_d = StLogC;
          phase_d = 2'd0;
        end else begin
          b_d = b_q + WW'(1);
          state_d = StInnerR;
        end
      end

      StLogC: begin
        if (phase_q == 2'd0) begin
          if (seen_q) begin
            phase_d = 2'd2;
          end else begin
            lg_start = 1'b1;
            phase_d  = 2'd1;
          end
        end else if (phase_q == 2'd1) begin
          if (lg_done) begin
            s_d     = s_q + 64'(cnt_q) * 64'(ldiff);
            phase_d = 2'd2;
          end
        end else begin
          phase_d = 2'd0;
          if (a_q == WW'(WINDOW_LEN - 1)) begin
            dv_req.start = 1'b1;
            dv_req.num   = s_q * 64'(psfet_pkg::FullScale) + (den_full >> 1);
            dv_req.den   = den_full[47:0];
            state_d = StDivH;
          end else begin
            a_d = a_q + WW'(1);
            state_d = StOuterR;
          end
        end
      end

      StDivH: begin
        if (dv_rsp.done) begin
          ent_h = (dv_rsp.quo > 64'(psfet_pkg::FullScale)) ?
                  15'(psfet_pkg::FullScale) : dv_rsp.quo[14:0];
          res_d.window_entropy = ent_h;
          if (rec_q.tally != 16'hFFFF) begin
            if (rec_q.tally == 16'd0) rec_d.efirst = ent_h;
            rec_d.elast = ent_h;
            rec_d.etot  = rec_q.etot + 32'(ent_h);
            rec_d.tally = rec_q.tally + 16'd1;
          end
          state_d = StRecord;
        end
      end

      StRecord: begin
        tab_we  = 1'b1;
        state_d = StDivM;
        phase_d = 2'd0;
      end

      StDivM: begin
        if (phase_q == 2'd0) begin
          if (rec_q.tally == 16'd0) begin
            res_d.mean_entropy = '0;
            phase_d = 2'd2;
          end else begin
            dv_req.start = 1'b1;
            dv_req.num   = 64'(rec_q.etot) + 64'(rec_q.tally >> 1);
            dv_req.den   = 48'(rec_q.tally);
            phase_d = 2'd1;
          end
        end else if (phase_q == 2'd1) begin
          if (dv_rsp.done) begin
            res_d.mean_entropy = dv_rsp.quo[14:0];
            phase_d = 2'd2;
          end
        end else begin
          phase_d = 2'd0;
          state_d = StDivS;
        end
      end

      StDivS: begin
        if (phase_q == 2'd0) begin
          slope_neg_d = rec_q.elast < rec_q.efirst;
          if (rec_q.tally < 16'd2) begin
            slope_mag_d = '0;
            phase_d = 2'd2;
          end else begin
            dv_req.start = 1'b1;
            dv_req.num   = 64'(dlt) + 64'(nm1 >> 1);
            dv_req.den   = 48'(nm1);
            phase_d = 2'd1;
          end
        end else if (phase_q == 2'd1) begin
          if (dv_rsp.done) begin
            slope_mag_d = dv_rsp.quo[15:0];
            phase_d = 2'd2;
          end
        end else begin
          res_d.status           = psfet_pkg::StatusOk;
          res_d.slot_index       = 6'(slot_q);
          res_d.source_addr      = rec_q.src;
          res_d.packet_sum       = rec_q.pkt;
          res_d.flow_sum         = rec_q.flw;
          res_d.duration_sum     = rec_q.dur;
          res_d.dst_change_total = rec_q.chg;
          res_d.windows_done     = rec_q.tally;
          res_d.entropy_slope    = slope_neg_q ? 16'(-slope_mag_q) : slope_mag_q;
          phase_d = 2'd0;
          state_d = StOut;
        end
      end

      StOut: begin
        if (out_fire) state_d = StIdle;
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      idx_q     <= '0;
      phase_q   <= '0;
      a_q       <= '0;
      b_q       <= '0;
      seen_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      phase_q   <= phase_d;
      a_q       <= a_d;
      b_q       <= b_d;
      seen_q    <= seen_d;
      cnt_q     <= cnt_d;
    end
  end

  // payload: capture on acceptance, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q    <= s_axis_tuser_i;
      src_q    <= s_axis_tdata_i[31:0];
      dst_q    <= s_axis_tdata_i[63:32];
      pkt_in_q <= s_axis_tdata_i[95:64];
      dur_in_q <= s_axis_tdata_i[127:96];
    end
    slot_q      <= slot_d;
    rec_q       <= rec_d;
    res_q       <= res_d;
    wa_q        <= wa_d;
    s_q         <= s_d;
    lw_q        <= lw_d;
    base_q      <= base_d;
    slope_mag_q <= slope_mag_d;
    slope_neg_q <= slope_neg_d;
  end

  // a read never changes the slot table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_q && state_q != StIdle) |-> !tab_we)
    else $error("slot table written during a read");

  // the slot count never passes the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(SOURCE_SLOTS))
    else $error("slot count overflow");

  // a held result stays put while the sink stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(res_q))
    else $error("result changed under stall");

  // no acceptance while a transaction is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !s_axis_tready_o)
    else $error("ready while busy");

endmodule
